### rtl/core/wsfr_pkg.sv
package wsfr_pkg;

   localparam int LENGTH_BITS = 64;

   typedef logic [LENGTH_BITS-1:0] len_type;

   typedef enum logic [2:0] {
      PH_H0   = 3'd0,
      PH_H1   = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_PAY  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      LS_HANDSHAKE      = 3'd0,
      LS_OPEN           = 3'd1,
      LS_CLOSING_SERVER = 3'd2,
      LS_CLOSING_CLIENT = 3'd3,
      LS_CLOSED         = 3'd4
   } link_type;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_FRAME   = 3'd1;
   localparam logic [2:0] EV_MESSAGE = 3'd2;
   localparam logic [2:0] EV_DISCARD = 3'd3;
   localparam logic [2:0] EV_ERROR   = 3'd4;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_PONG  = 2'd1;
   localparam logic [1:0] ACT_CLOSE = 2'd2;
   localparam logic [1:0] ACT_SEEN  = 2'd3;

   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_RSV        = 4'd1;
   localparam logic [3:0] ERR_HANDSHAKE  = 4'd2;
   localparam logic [3:0] ERR_STRAY_CONT = 4'd3;
   localparam logic [3:0] ERR_DATA_IN_FR = 4'd4;
   localparam logic [3:0] ERR_FRAG_CTRL  = 4'd5;
   localparam logic [3:0] ERR_LONG_CTRL  = 4'd6;
   localparam logic [3:0] ERR_OPCODE     = 4'd7;
   localparam logic [3:0] ERR_TOO_BIG    = 4'd8;
   localparam logic [3:0] ERR_CLOSE_ONE  = 4'd9;
   localparam logic [3:0] ERR_CLOSE_CODE = 4'd10;

   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   localparam logic [15:0] CODE_NORMAL   = 16'd1000;
   localparam logic [15:0] CODE_PROTOCOL = 16'd1002;
   localparam logic [15:0] CODE_TOO_BIG  = 16'd1009;

   localparam logic [1:0] CSR_COMPRESSION = 2'd0;
   localparam logic [1:0] CSR_MAX_PAYLOAD = 2'd1;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        payload_is_control;
      logic [3:0]  message_opcode;
      logic        message_compressed;
      logic [2:0]  frame_event;
      logic [1:0]  action;
      logic [15:0] close_code;
      logic [3:0]  error_reason;
      logic [2:0]  connection_state;
      logic        disconnect;
   } rsp_type;

   function automatic logic close_code_ok(input logic [15:0] c);
      logic in_range;
      in_range = (c >= 16'd1000 && c <= 16'd1011) || (c >= 16'd3000 && c <= 16'd4999);
      return in_range && c != 16'd1004 && c != 16'd1005 && c != 16'd1006;
   endfunction

endpackage

### rtl/core/websocket_frame_receiver_unit.sv
// Throughput: one item per cycle while req_stall is low; each byte passes through one stage of parse logic.
// The output register holds a result under rsp_stall while a new item is still taken
// into the skid register, so req_stall rises only when both are full.
// Reset is synchronous and active high; it puts the parser before a first header byte,
// the link in handshake and the registers at compression off and a 1 MiB payload limit.
module websocket_frame_receiver_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wsfr_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wsfr_pkg::rsp_type     rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic                 compression_ff;
   logic [31:0]          max_payload_ff;
   wsfr_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]           flags_ff, flags_in;
   logic [3:0]           count_ff, count_in;
   wsfr_pkg::len_type    left_ff, left_in;
   logic [31:0]          key_ff, key_in;
   logic [1:0]           midx_ff, midx_in;
   wsfr_pkg::link_type   link_ff, link_in;
   logic                 frag_ff, frag_in;
   logic [3:0]           cur_op_ff, cur_op_in;
   logic                 cur_comp_ff, cur_comp_in;
   logic                 disc_ff, disc_in;
   logic [15:0]          rcode_ff, rcode_in;
   logic [1:0]           cseen_ff, cseen_in;
   logic                 failed_ff, failed_in;
   logic                 masked_ff, masked_in;
   logic                 ovf_ff, ovf_in;

   logic                 out_valid_ff, skid_valid_ff;
   wsfr_pkg::rsp_type    out_ff, skid_ff, res;
   logic                 take;

   assign pready    = 1'b1;
   assign req_stall = skid_valid_ff;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      case (paddr[2])
         wsfr_pkg::CSR_COMPRESSION[0]: prdata = {31'd0, compression_ff};
         default:                      prdata = max_payload_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compression_ff <= 1'b0;
         max_payload_ff <= 32'd1048576;
      end else if (psel && penable && pwrite) begin
         if (paddr == {wsfr_pkg::CSR_COMPRESSION[0], 2'b00})
            compression_ff <= pwdata[0];
         else if (paddr == {wsfr_pkg::CSR_MAX_PAYLOAD[0], 2'b00})
            max_payload_ff <= pwdata;
      end
   end

   // The whole step of the parser for one item.
   always_comb begin
      logic [3:0] op;
      logic       fin, rsv1, ctrl, endf, hdr, err, allowed;
      logic [3:0] reason;
      logic [7:0] b, k, v;
      wsfr_pkg::len_type left_dec;
      phase_in = phase_ff; flags_in = flags_ff; count_in = count_ff; left_in = left_ff;
      key_in = key_ff; midx_in = midx_ff; link_in = link_ff; frag_in = frag_ff;
      cur_op_in = cur_op_ff; cur_comp_in = cur_comp_ff; disc_in = disc_ff;
      rcode_in = rcode_ff; cseen_in = cseen_ff; failed_in = failed_ff;
      masked_in = masked_ff; ovf_in = ovf_ff;
      res = '0;
      b = req_data.rx_byte;
      op = flags_ff[3:0]; fin = flags_ff[7]; rsv1 = flags_ff[6]; ctrl = op[3];
      endf = 1'b0; hdr = 1'b0; err = 1'b0; reason = wsfr_pkg::ERR_NONE;
      // Key bytes are used most significant first.
      k = key_ff[{~midx_ff, 3'b000} +: 8];
      v = b ^ k;
      left_dec = left_ff - wsfr_pkg::len_type'(1);
      allowed = 1'b0;

      if (req_data.command) begin
         if (link_ff == wsfr_pkg::LS_HANDSHAKE) link_in = wsfr_pkg::LS_OPEN;
      end else if (!failed_ff) begin
         case (phase_ff)
            wsfr_pkg::PH_H0: begin
               flags_in = b;
               phase_in = wsfr_pkg::PH_H1;
            end
            wsfr_pkg::PH_H1: begin
               masked_in = b[7];
               ovf_in = 1'b0;
               key_in = '0;
               if (b[6:0] < 7'd126) begin
                  left_in = wsfr_pkg::len_type'(b[6:0]);
                  if (b[7]) begin
                     count_in = 4'd4; phase_in = wsfr_pkg::PH_MASK;
                  end else hdr = 1'b1;
               end else begin
                  left_in = '0;
                  count_in = (b[6:0] == 7'd126) ? 4'd2 : 4'd8;
                  phase_in = wsfr_pkg::PH_EXT;
               end
            end
            wsfr_pkg::PH_EXT: begin
               if (left_ff[wsfr_pkg::LENGTH_BITS-1 -: 8] != 8'd0) ovf_in = 1'b1;
               left_in = {left_ff[wsfr_pkg::LENGTH_BITS-9:0], b};
               count_in = count_ff - 4'd1;
               if (count_ff == 4'd1) begin
                  key_in = '0;
                  if (masked_ff) begin
                     count_in = 4'd4; phase_in = wsfr_pkg::PH_MASK;
                  end else hdr = 1'b1;
               end
            end
            wsfr_pkg::PH_MASK: begin
               key_in = {key_ff[23:0], b};
               count_in = count_ff - 4'd1;
               if (count_ff == 4'd1) hdr = 1'b1;
            end
            wsfr_pkg::PH_PAY: begin
               if (!disc_ff) begin
                  midx_in = midx_ff + 2'd1;
                  res.payload_valid = 1'b1;
                  res.payload_byte = v;
                  res.payload_is_control = ctrl;
                  if (op == wsfr_pkg::OP_CLOSE) begin
                     if (cseen_ff == 2'd0) begin
                        rcode_in = {v, 8'd0}; cseen_in = 2'd1;
                     end else if (cseen_ff == 2'd1) begin
                        rcode_in = {rcode_ff[15:8], v}; cseen_in = 2'd2;
                     end
                  end
               end
               left_in = left_dec;
               if (left_dec == '0) endf = 1'b1;
            end
            default: phase_in = wsfr_pkg::PH_H0;
         endcase
      end

      // Header checks, using the new length and overflow.
      if (hdr) begin
         if (flags_ff[5:4] != 2'b00 || (rsv1 && !compression_ff)) begin
            err = 1'b1; reason = wsfr_pkg::ERR_RSV;
         end else if (link_ff == wsfr_pkg::LS_HANDSHAKE) begin
            err = 1'b1; reason = wsfr_pkg::ERR_HANDSHAKE;
         end else begin
            allowed = link_ff == wsfr_pkg::LS_OPEN ||
                      (link_ff == wsfr_pkg::LS_CLOSING_SERVER && ctrl);
            if (!allowed) begin
               disc_in = 1'b1;
            end else if (op == wsfr_pkg::OP_CONT && frag_ff && rsv1) begin
               err = 1'b1; reason = wsfr_pkg::ERR_RSV;
            end else if (op == wsfr_pkg::OP_CONT && !frag_ff) begin
               err = 1'b1; reason = wsfr_pkg::ERR_STRAY_CONT;
            end else if ((op == wsfr_pkg::OP_TEXT || op == wsfr_pkg::OP_BIN) && frag_ff) begin
               err = 1'b1; reason = wsfr_pkg::ERR_DATA_IN_FR;
            end else if ((op == wsfr_pkg::OP_CLOSE || op == wsfr_pkg::OP_PING ||
                          op == wsfr_pkg::OP_PONG) && !fin) begin
               err = 1'b1; reason = wsfr_pkg::ERR_FRAG_CTRL;
            end else if ((op == wsfr_pkg::OP_CLOSE || op == wsfr_pkg::OP_PING ||
                          op == wsfr_pkg::OP_PONG) &&
                         (ovf_in || left_in > wsfr_pkg::len_type'(125))) begin
               err = 1'b1; reason = wsfr_pkg::ERR_LONG_CTRL;
            end else if (op != wsfr_pkg::OP_CONT && op != wsfr_pkg::OP_TEXT &&
                         op != wsfr_pkg::OP_BIN && op != wsfr_pkg::OP_CLOSE &&
                         op != wsfr_pkg::OP_PING && op != wsfr_pkg::OP_PONG) begin
               err = 1'b1; reason = wsfr_pkg::ERR_OPCODE;
            end else if (ovf_in || 64'(left_in) > {32'd0, max_payload_ff}) begin
               err = 1'b1; reason = wsfr_pkg::ERR_TOO_BIG;
            end else begin
               if (op == wsfr_pkg::OP_TEXT || op == wsfr_pkg::OP_BIN) begin
                  cur_op_in = op; cur_comp_in = rsv1; frag_in = !fin;
               end
               if (op == wsfr_pkg::OP_CLOSE) begin
                  rcode_in = wsfr_pkg::CODE_NORMAL; cseen_in = 2'd0;
               end
            end
         end
         if (!err) begin
            midx_in = 2'd0;
            if (left_in == '0) endf = 1'b1;
            else phase_in = wsfr_pkg::PH_PAY;
         end
      end

      // End of frame, on the updated close bookkeeping.
      if (endf) begin
         phase_in = wsfr_pkg::PH_H0;
         if (disc_in) begin
            disc_in = 1'b0; res.frame_event = wsfr_pkg::EV_DISCARD;
         end else if (ctrl) begin
            res.frame_event = wsfr_pkg::EV_FRAME;
            if (op == wsfr_pkg::OP_CLOSE) begin
               if (cseen_in == 2'd1) begin
                  err = 1'b1; reason = wsfr_pkg::ERR_CLOSE_ONE;
               end else if (cseen_in == 2'd2 && !wsfr_pkg::close_code_ok(rcode_in)) begin
                  err = 1'b1; reason = wsfr_pkg::ERR_CLOSE_CODE;
               end else if (link_ff == wsfr_pkg::LS_OPEN) begin
                  res.action = wsfr_pkg::ACT_CLOSE;
                  res.close_code = (cseen_in == 2'd0) ? wsfr_pkg::CODE_NORMAL : rcode_in;
                  link_in = wsfr_pkg::LS_CLOSING_CLIENT;
                  res.disconnect = 1'b1; failed_in = 1'b1;
               end else if (link_ff == wsfr_pkg::LS_CLOSING_SERVER) begin
                  link_in = wsfr_pkg::LS_CLOSED;
                  res.disconnect = 1'b1; failed_in = 1'b1;
               end
            end else if (op == wsfr_pkg::OP_PING) begin
               if (link_ff == wsfr_pkg::LS_OPEN || link_ff == wsfr_pkg::LS_CLOSING_SERVER)
                  res.action = wsfr_pkg::ACT_PONG;
            end else if (op == wsfr_pkg::OP_PONG) begin
               if (link_ff == wsfr_pkg::LS_OPEN) res.action = wsfr_pkg::ACT_SEEN;
            end
         end else if (fin) begin
            frag_in = 1'b0; res.frame_event = wsfr_pkg::EV_MESSAGE;
         end else res.frame_event = wsfr_pkg::EV_FRAME;
      end

      if (err) begin
         res.frame_event = wsfr_pkg::EV_ERROR;
         res.error_reason = reason;
         res.action = wsfr_pkg::ACT_CLOSE;
         res.close_code = (reason == wsfr_pkg::ERR_TOO_BIG) ? wsfr_pkg::CODE_TOO_BIG
                                                            : wsfr_pkg::CODE_PROTOCOL;
         res.disconnect = 1'b1;
         failed_in = 1'b1;
         if (link_ff == wsfr_pkg::LS_OPEN) link_in = wsfr_pkg::LS_CLOSING_SERVER;
         else if (link_ff != wsfr_pkg::LS_CLOSING_SERVER &&
                  link_ff != wsfr_pkg::LS_CLOSING_CLIENT) link_in = wsfr_pkg::LS_CLOSED;
         disc_in = 1'b0;
         phase_in = wsfr_pkg::PH_H0;
      end

      res.message_opcode = cur_op_in;
      res.message_compressed = cur_comp_in;
      res.connection_state = link_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsfr_pkg::PH_H0; flags_ff <= '0; count_ff <= '0; left_ff <= '0;
         key_ff <= '0; midx_ff <= '0; link_ff <= wsfr_pkg::LS_HANDSHAKE; frag_ff <= 1'b0;
         cur_op_ff <= '0; cur_comp_ff <= 1'b0; disc_ff <= 1'b0;
         rcode_ff <= wsfr_pkg::CODE_NORMAL; cseen_ff <= '0; failed_ff <= 1'b0;
         masked_ff <= 1'b0; ovf_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in; flags_ff <= flags_in; count_ff <= count_in; left_ff <= left_in;
         key_ff <= key_in; midx_ff <= midx_in; link_ff <= link_in; frag_ff <= frag_in;
         cur_op_ff <= cur_op_in; cur_comp_ff <= cur_comp_in; disc_ff <= disc_in;
         rcode_ff <= rcode_in; cseen_ff <= cseen_in; failed_ff <= failed_in;
         masked_ff <= masked_in; ovf_ff <= ovf_in;
      end
   end

   // Output register with a skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || !rsp_stall) begin
            if (skid_valid_ff) begin
               out_valid_ff <= 1'b1; out_ff <= skid_ff; skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= take;
               if (take) out_ff <= res;
            end
         end else if (take) begin
            skid_valid_ff <= 1'b1; skid_ff <= res;
         end
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
   a_skid_only_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid full with empty output");
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff)
      else $error("failed flag cleared");
   a_disc_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_event == wsfr_pkg::EV_ERROR |-> rsp_data.disconnect)
      else $error("error without disconnect");

endmodule

### tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wsfr_pkg::*;

   typedef logic [7:0] byte_q [$];

   typedef struct {
      req_type    r;
      logic       chk;
      logic [2:0] ev;
      link_type   st;
   } stim_item;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   websocket_frame_receiver_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   stim_item  byte_stream [$];
   rsp_type   frame_results [$];
   stim_item  cur_item;
   rsp_type   want;
   int        item_count = 0;
   int        errors = 0;
   int        send_idle = 29;
   int        recv_idle = 66;
   int        ending;

   // Mirror of the receiver's registers and parser state.
   logic        cfg_comp = 1'b0;
   logic [31:0] cfg_max = 32'd1048576;
   phase_type   m_phase = PH_H0;
   logic [7:0]  m_hdr = '0;
   logic [3:0]  m_count = '0;
   logic [63:0] m_left = '0;
   logic [31:0] m_key = '0;
   logic [1:0]  m_kidx = '0;
   link_type    m_link = LS_HANDSHAKE;
   logic        m_frag = 1'b0;
   logic [3:0]  m_op = '0;
   logic        m_comp = 1'b0;
   logic        m_discard = 1'b0;
   logic [15:0] m_rcode = 16'd1000;
   logic [1:0]  m_cbytes = '0;
   logic        m_dead = 1'b0;
   logic        m_masked = 1'b0;
   logic        m_ovf = 1'b0;
   rsp_type     pr;

   function automatic void abort_link(input logic [3:0] reason, input logic [15:0] code);
      pr.frame_event = EV_ERROR;
      pr.error_reason = reason;
      pr.action = ACT_CLOSE;
      pr.close_code = code;
      pr.disconnect = 1'b1;
      m_dead = 1'b1;
      if (m_link == LS_OPEN) m_link = LS_CLOSING_SERVER;
      else if (m_link != LS_CLOSING_SERVER && m_link != LS_CLOSING_CLIENT) m_link = LS_CLOSED;
      m_discard = 1'b0;
      m_phase = PH_H0;
   endfunction

   function automatic logic close_code_allowed(input logic [15:0] c);
      if (!((c >= 16'd1000 && c <= 16'd1011) || (c >= 16'd3000 && c <= 16'd4999)))
         return 1'b0;
      return c != 16'd1004 && c != 16'd1005 && c != 16'd1006;
   endfunction

   function automatic void close_frame();
      logic [3:0] op;
      op = m_hdr[3:0];
      m_phase = PH_H0;
      if (m_discard) begin
         m_discard = 1'b0;
         pr.frame_event = EV_DISCARD;
         return;
      end
      if (op[3]) begin
         if (op == OP_CLOSE) begin
            if (m_cbytes == 2'd1) begin
               abort_link(ERR_CLOSE_ONE, CODE_PROTOCOL);
               return;
            end
            if (m_cbytes >= 2'd2 && !close_code_allowed(m_rcode)) begin
               abort_link(ERR_CLOSE_CODE, CODE_PROTOCOL);
               return;
            end
            if (m_link == LS_OPEN) begin
               pr.action = ACT_CLOSE;
               pr.close_code = (m_cbytes == 2'd0) ? CODE_NORMAL : m_rcode;
               m_link = LS_CLOSING_CLIENT;
               pr.disconnect = 1'b1;
               m_dead = 1'b1;
            end else if (m_link == LS_CLOSING_SERVER) begin
               m_link = LS_CLOSED;
               pr.disconnect = 1'b1;
               m_dead = 1'b1;
            end
         end else if (op == OP_PING) begin
            if (m_link == LS_OPEN || m_link == LS_CLOSING_SERVER) pr.action = ACT_PONG;
         end else if (op == OP_PONG) begin
            if (m_link == LS_OPEN) pr.action = ACT_SEEN;
         end
         pr.frame_event = EV_FRAME;
         return;
      end
      if (m_hdr[7]) begin
         m_frag = 1'b0;
         pr.frame_event = EV_MESSAGE;
      end else begin
         pr.frame_event = EV_FRAME;
      end
   endfunction

   function automatic void check_header();
      logic [3:0] op;
      logic       fin;
      logic       rsv1;
      op = m_hdr[3:0];
      fin = m_hdr[7];
      rsv1 = m_hdr[6];
      if (m_hdr[5:4] != 2'b00 || (rsv1 && !cfg_comp)) begin
         abort_link(ERR_RSV, CODE_PROTOCOL);
         return;
      end
      if (m_link == LS_HANDSHAKE) begin
         abort_link(ERR_HANDSHAKE, CODE_PROTOCOL);
         return;
      end
      if (!(m_link == LS_OPEN || (m_link == LS_CLOSING_SERVER && op[3]))) begin
         m_discard = 1'b1;
         m_kidx = '0;
         if (m_left == 0) close_frame();
         else m_phase = PH_PAY;
         return;
      end
      if (op == OP_CONT && m_frag && rsv1) begin
         abort_link(ERR_RSV, CODE_PROTOCOL);
         return;
      end
      if (op == OP_CONT) begin
         if (!m_frag) begin
            abort_link(ERR_STRAY_CONT, CODE_PROTOCOL);
            return;
         end
      end else if (op == OP_TEXT || op == OP_BIN) begin
         if (m_frag) begin
            abort_link(ERR_DATA_IN_FR, CODE_PROTOCOL);
            return;
         end
      end else if (op == OP_CLOSE || op == OP_PING || op == OP_PONG) begin
         if (!fin) begin
            abort_link(ERR_FRAG_CTRL, CODE_PROTOCOL);
            return;
         end
         if (m_ovf || m_left > 64'd125) begin
            abort_link(ERR_LONG_CTRL, CODE_PROTOCOL);
            return;
         end
      end else begin
         abort_link(ERR_OPCODE, CODE_PROTOCOL);
         return;
      end
      if (m_ovf || m_left > {32'd0, cfg_max}) begin
         abort_link(ERR_TOO_BIG, CODE_TOO_BIG);
         return;
      end
      if (op == OP_TEXT || op == OP_BIN) begin
         m_op = op;
         m_comp = rsv1;
         m_frag = !fin;
      end
      if (op == OP_CLOSE) begin
         m_rcode = CODE_NORMAL;
         m_cbytes = '0;
      end
      m_kidx = '0;
      if (m_left == 0) close_frame();
      else m_phase = PH_PAY;
   endfunction

   function automatic void length_known();
      m_key = '0;
      if (m_masked) begin
         m_count = 4'd4;
         m_phase = PH_MASK;
      end else begin
         check_header();
      end
   endfunction

   function automatic rsp_type ws_rx_step(input req_type r);
      logic [7:0] b;
      logic [7:0] v;
      b = r.rx_byte;
      pr = '0;
      if (r.command) begin
         if (m_link == LS_HANDSHAKE) m_link = LS_OPEN;
      end else if (!m_dead) begin
         case (m_phase)
            PH_H0: begin
               m_hdr = b;
               m_phase = PH_H1;
            end
            PH_H1: begin
               m_masked = b[7];
               m_ovf = 1'b0;
               if (b[6:0] < 7'd126) begin
                  m_left = {57'd0, b[6:0]};
                  length_known();
               end else begin
                  m_left = '0;
                  m_count = (b[6:0] == 7'd126) ? 4'd2 : 4'd8;
                  m_phase = PH_EXT;
               end
            end
            PH_EXT: begin
               if (m_left[63:56] != 8'd0) m_ovf = 1'b1;
               m_left = {m_left[55:0], b};
               m_count = m_count - 4'd1;
               if (m_count == 0) length_known();
            end
            PH_MASK: begin
               m_key = {m_key[23:0], b};
               m_count = m_count - 4'd1;
               if (m_count == 0) check_header();
            end
            PH_PAY: begin
               if (!m_discard) begin
                  v = b ^ m_key[31 - 8*m_kidx -: 8];
                  m_kidx = m_kidx + 2'd1;
                  pr.payload_valid = 1'b1;
                  pr.payload_byte = v;
                  pr.payload_is_control = m_hdr[3];
                  if (m_hdr[3:0] == OP_CLOSE) begin
                     if (m_cbytes == 2'd0) begin
                        m_rcode = {v, 8'd0};
                        m_cbytes = 2'd1;
                     end else if (m_cbytes == 2'd1) begin
                        m_rcode[7:0] = v;
                        m_cbytes = 2'd2;
                     end
                  end
               end
               m_left = m_left - 64'd1;
               if (m_left == 0) close_frame();
            end
            default: m_phase = PH_H0;
         endcase
      end
      pr.message_opcode = m_op;
      pr.message_compressed = m_comp;
      pr.connection_state = m_link;
      return pr;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] exp_val);
      $display("%0t: %s got %0d, expected %0d", $realtime, what, got, exp_val);
      errors++;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Sender: the payload only moves on when the current item has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            want = ws_rx_step(req_data);
            if (cur_item.chk) begin
               want.frame_event = cur_item.ev;
               want.connection_state = cur_item.st;
            end
            frame_results.push_back(want);
         end
         if (!req_valid || !req_stall) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle) begin
               cur_item = byte_stream.pop_front();
               req_valid <= 1'b1;
               req_data <= cur_item.r;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_results.size() == 0) begin
            report_mismatch("unexpected item", 16'd1, 16'd0);
         end else begin
            e = frame_results.pop_front();
            if (rsp_data.payload_valid !== e.payload_valid)
               report_mismatch("payload_valid", rsp_data.payload_valid, e.payload_valid);
            if (rsp_data.payload_byte !== e.payload_byte)
               report_mismatch("payload_byte", rsp_data.payload_byte, e.payload_byte);
            if (rsp_data.payload_is_control !== e.payload_is_control)
               report_mismatch("payload_is_control", rsp_data.payload_is_control,
                               e.payload_is_control);
            if (rsp_data.message_opcode !== e.message_opcode)
               report_mismatch("message_opcode", rsp_data.message_opcode, e.message_opcode);
            if (rsp_data.message_compressed !== e.message_compressed)
               report_mismatch("message_compressed", rsp_data.message_compressed,
                               e.message_compressed);
            if (rsp_data.frame_event !== e.frame_event)
               report_mismatch("frame_event", rsp_data.frame_event, e.frame_event);
            if (rsp_data.action !== e.action)
               report_mismatch("action", rsp_data.action, e.action);
            if (rsp_data.close_code !== e.close_code)
               report_mismatch("close_code", rsp_data.close_code, e.close_code);
            if (rsp_data.error_reason !== e.error_reason)
               report_mismatch("error_reason", rsp_data.error_reason, e.error_reason);
            if (rsp_data.connection_state !== e.connection_state)
               report_mismatch("connection_state", rsp_data.connection_state,
                               e.connection_state);
            if (rsp_data.disconnect !== e.disconnect)
               report_mismatch("disconnect", rsp_data.disconnect, e.disconnect);
         end
      end
   end

   task automatic push_item(input logic cmd, input logic [7:0] b);
      stim_item s;
      s.r.command = cmd;
      s.r.rx_byte = b;
      s.chk = 1'b0;
      s.ev = EV_NONE;
      s.st = LS_HANDSHAKE;
      byte_stream.push_back(s);
      item_count++;
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] d);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 1'b0} << 1;
      pwdata <= d;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (index == CSR_COMPRESSION) cfg_comp = d[0];
      else if (index == CSR_MAX_PAYLOAD) cfg_max = d;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (byte_stream.size() != 0 || req_valid);
      while (frame_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic byte_q random_bytes(input int n);
      byte_q q;
      for (int i = 0; i < n; i++) q.push_back($urandom);
      return q;
   endfunction

   function automatic int pick_length_form(input int n);
      int r;
      if (n >= 126) return 1 + $urandom_range(1);
      r = $urandom_range(7);
      return (r < 6) ? 0 : r - 5;
   endfunction

   // Builds one frame on the wire: header, length in given form, key if masked, payload.
   task automatic send_frame(input logic [7:0] h, input logic mask_on, input logic [63:0] len,
                             input int form, input byte_q pl);
      logic [31:0] k;
      k = mask_on ? $urandom : 32'd0;
      push_item(1'b0, h);
      if (form == 0) begin
         push_item(1'b0, {mask_on, len[6:0]});
      end else if (form == 1) begin
         push_item(1'b0, {mask_on, 7'd126});
         push_item(1'b0, len[15:8]);
         push_item(1'b0, len[7:0]);
      end else begin
         push_item(1'b0, {mask_on, 7'd127});
         for (int i = 7; i >= 0; i--) push_item(1'b0, len[8*i +: 8]);
      end
      if (mask_on)
         for (int i = 3; i >= 0; i--) push_item(1'b0, k[8*i +: 8]);
      for (int i = 0; i < pl.size(); i++) push_item(1'b0, pl[i] ^ k[31 - 8*(i % 4) -: 8]);
   endtask

   task automatic send_simple(input logic [7:0] h, input int n);
      send_frame(h, $urandom_range(3) != 0, n, pick_length_form(n), random_bytes(n));
   endtask

   task automatic send_control(input logic [3:0] op);
      int n;
      n = $urandom_range(0, $urandom_range(1) ? 125 : 8);
      send_simple({1'b1, cfg_comp & 1'($urandom_range(1)), 2'b00, op}, n);
   endtask

   task automatic random_traffic(input int target);
      int c;
      int parts;
      logic [3:0] op;
      logic rsv;
      while (item_count < target) begin
         c = $urandom_range(15);
         op = $urandom_range(1) ? OP_TEXT : OP_BIN;
         rsv = cfg_comp & $urandom_range(1);
         if (c == 0) begin
            push_item(1'b1, $urandom);
         end else if (c <= 7) begin
            send_simple({1'b1, rsv, 2'b00, op},
                        $urandom_range(0, ($urandom_range(3) == 0) ? 150 : 20));
         end else if (c <= 11) begin
            parts = $urandom_range(1, 3);
            send_simple({1'b0, rsv, 2'b00, op}, $urandom_range(0, 12));
            for (int i = 1; i <= parts; i++) begin
               if ($urandom_range(3) == 0) send_control(OP_PING);
               send_simple({i == parts, 3'b000, OP_CONT}, $urandom_range(0, 12));
            end
         end else begin
            send_control((c < 14) ? OP_PING : OP_PONG);
         end
      end
   endtask

   // One way of ending the connection for good; nothing after it has any effect.
   task automatic end_connection(input int s);
      byte_q pl;
      logic [15:0] code;
      case (s)
         0: send_simple(cfg_comp ? 8'hA1 : ($urandom_range(1) ? 8'hC2 : 8'h91), 3);
         1: send_simple({1'b1, 3'b000, OP_CONT}, 2);
         2: begin
            send_simple({1'b0, 3'b000, OP_TEXT}, 2);
            send_simple({1'b1, 3'b000, OP_BIN}, 2);
         end
         3: send_simple({1'b0, 3'b000, OP_PING}, 1);
         4: send_frame({1'b1, 3'b000, OP_PING}, 1'b1, $urandom_range(126, 200), 1,
                       random_bytes(0));
         5: send_simple({1'b1, 3'b000, 4'($urandom_range(1) ? $urandom_range(3, 7)
                                             : $urandom_range(11, 15))}, 2);
         6: send_frame({1'b1, 3'b000, OP_BIN}, $urandom_range(1), 64'hFFFF_FFFF_FFFF_FFFF, 2,
                       random_bytes(0));
         7: send_simple({1'b1, 3'b000, OP_CLOSE}, 1);
         8, 9: begin
            if (s == 8) code = ($urandom_range(1)) ? 16'd1004 + $urandom_range(2)
                                                   : 16'($urandom_range(5000, 65535));
            else code = ($urandom_range(1)) ? 16'($urandom_range(1000, 1003))
                                            : 16'($urandom_range(3000, 4999));
            pl = random_bytes($urandom_range(0, 6));
            pl.push_front(code[7:0]);
            pl.push_front(code[15:8]);
            send_frame({1'b1, 3'b000, OP_CLOSE}, 1'b1, pl.size(), 0, pl);
         end
         default: send_simple({1'b1, 3'b000, OP_CLOSE}, 0);
      endcase
      repeat (30) push_item($urandom_range(1), $urandom);
   endtask

   stim_item dir_tab [25];

   initial begin
      stim_item row;
      reset = 1'b1;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      ending = $urandom_range(11);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      csr_write(CSR_COMPRESSION, 32'd0);
      csr_write(CSR_MAX_PAYLOAD, 32'd200);

      // A frame before the opening handshake kills the link for the rest of the run.
      if (ending == 11) send_simple({1'b1, 3'b000, OP_TEXT}, 0);

      dir_tab = '{
         '{'{1'b1, 8'h00}, 1'b1, EV_NONE, LS_OPEN},
         '{'{1'b1, 8'hFF}, 1'b1, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h81}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h82}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h37}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'hFA}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h21}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h3D}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h00}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'hFF}, 1'b1, EV_MESSAGE, LS_OPEN},
         '{'{1'b0, 8'h89}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h00}, 1'b1, EV_FRAME, LS_OPEN},
         '{'{1'b0, 8'h8A}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h00}, 1'b1, EV_FRAME, LS_OPEN},
         '{'{1'b0, 8'h02}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h01}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h5A}, 1'b1, EV_FRAME, LS_OPEN},
         '{'{1'b0, 8'h80}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h01}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'hA5}, 1'b1, EV_MESSAGE, LS_OPEN},
         '{'{1'b0, 8'h81}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h7E}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h00}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h01}, 1'b0, EV_NONE, LS_OPEN},
         '{'{1'b0, 8'h7F}, 1'b1, EV_MESSAGE, LS_OPEN}
      };
      // The typed expectations only hold while the link is still alive.
      foreach (dir_tab[i]) begin
         row = dir_tab[i];
         if (ending == 11) row.chk = 1'b0;
         byte_stream.push_back(row);
         item_count++;
      end

      random_traffic(300);
      wait_drained();

      send_idle = 66;
      recv_idle = 29;
      csr_write(CSR_COMPRESSION, 32'd1);
      csr_write(CSR_MAX_PAYLOAD, 32'hFFFF_FFFF);
      random_traffic(600);
      wait_drained();

      send_idle = 0;
      recv_idle = 0;
      csr_write(CSR_COMPRESSION, $urandom_range(1));
      csr_write(CSR_MAX_PAYLOAD, 32'd150);
      random_traffic(880);
      wait_drained();

      case ($urandom_range(3))
         0: csr_write(CSR_MAX_PAYLOAD, 32'd0);
         1: csr_write(CSR_MAX_PAYLOAD, 32'd1);
         2: csr_write(CSR_MAX_PAYLOAD, 32'd2);
         default: csr_write(CSR_MAX_PAYLOAD, 32'hFFFF_FFFF);
      endcase
      end_connection(ending);
      wait_drained();
      repeat (10) @(posedge clock);

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
